// File: rtl/pbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbl_pkg
// Widths, operation and status codes, and the words passed along the cell
// chain of the positional byte list.
// ----------------------------------------------------------------------------
package pbl_pkg;

	localparam int OP_W   = 2;
	localparam int POS_W  = 5;
	localparam int DATA_W = 8;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

	// shift control broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [POS_W-1:0]  tgt;
		logic [DATA_W-1:0] value;
	} shift_ctl_t;

	// query word walking the chain, one cell per cycle
	typedef struct packed {
		logic              vld;
		logic              find;
		logic [POS_W-1:0]  tgt;
		logic [DATA_W-1:0] value;
		logic              hit;
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  found;
	} query_t;

endpackage

// File: rtl/pbl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbl_cell
// One list entry: holds a byte, shifts with its neighbors on insert and
// delete, and checks the passing query word before handing it on.
// ----------------------------------------------------------------------------
module pbl_cell #(
	parameter int CAPACITY = 16,
	parameter int IDX      = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pbl_pkg::shift_ctl_t            ctl_i,
	input  logic [pbl_pkg::DATA_W-1:0]     left_i,
	input  logic [pbl_pkg::DATA_W-1:0]     right_i,
	input  logic [$clog2(CAPACITY+1)-1:0]  count_i,
	input  pbl_pkg::query_t                qry_i,
	output logic [pbl_pkg::DATA_W-1:0]     byte_o,
	output pbl_pkg::query_t                qry_o
);
	import pbl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > POS_W) ? CW : POS_W;
	localparam logic [MW-1:0] IDX_M = MW'(IDX);

	logic [DATA_W-1:0] byte_q;
	query_t            qry_q;
	query_t            qry_nxt;
	logic [MW-1:0]     shift_tgt;
	logic [MW-1:0]     qry_tgt;

	assign shift_tgt = MW'(ctl_i.tgt);
	assign qry_tgt   = MW'(qry_i.tgt);

	always_ff @(posedge clk) begin
		if (ctl_i.ins) begin
			if (IDX_M == shift_tgt) begin
				byte_q <= ctl_i.value;
			end else if (IDX_M > shift_tgt) begin
				byte_q <= left_i;
			end
		end else if (ctl_i.del && IDX_M >= shift_tgt) begin
			byte_q <= right_i;
		end
	end

	always_comb begin
		qry_nxt = qry_i;
		if (qry_i.vld && !qry_i.hit && CW'(IDX) < count_i) begin
			if (qry_i.find) begin
				if (byte_q == qry_i.value) begin
					qry_nxt.hit   = 1'b1;
					qry_nxt.found = POS_W'(IDX + 1);
				end
			end else if (qry_tgt == IDX_M) begin
				qry_nxt.hit  = 1'b1;
				qry_nxt.data = byte_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qry_q <= '0;
		end else begin
			qry_q <= qry_nxt;
		end
	end

	assign byte_o = byte_q;
	assign qry_o  = qry_q;

endmodule

// File: rtl/positional_byte_list_core.sv
`timescale 1ns / 1ps
// Insert, and any request rejected for range or full list: result in the cycle
// after start, busy stays low, so a new word may follow every cycle.
// Read, delete and find: a query walks the chain one cell per cycle; result
// registered once the query leaves the last cell, busy high meanwhile.
// Reset clears the count, busy and the query chain; stored bytes are
// undefined until written. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// positional_byte_list_core
// Ordered byte list with insert, delete, read and find at 1-based positions,
// built as a chain of entry cells.
// ----------------------------------------------------------------------------
module positional_byte_list_core #(
	parameter int CAPACITY = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [pbl_pkg::OP_W-1:0]     op,
	input  logic [pbl_pkg::POS_W-1:0]    position,
	input  logic [pbl_pkg::DATA_W-1:0]   value,
	output logic                         done,
	output logic [pbl_pkg::DATA_W-1:0]   data,
	output logic [pbl_pkg::POS_W-1:0]    found_position,
	output logic [pbl_pkg::POS_W-1:0]    count,
	output logic [pbl_pkg::STAT_W-1:0]   status
);
	import pbl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]     count_q;
	logic              busy_q;
	logic              del_q;
	logic [POS_W-1:0]  del_tgt_q;
	logic              done_q;
	logic [DATA_W-1:0] data_q;
	logic [POS_W-1:0]  found_q;
	logic [STAT_W-1:0] status_q;

	logic              accept;
	logic              ins_ok;
	logic              rng_ok;
	logic              launch;
	logic              retire;
	logic [MW-1:0]     pos_m;
	logic [MW-1:0]     cnt_m;
	logic [POS_W-1:0]  tgt;
	shift_ctl_t        ctl;
	query_t            qry [CAPACITY+1];
	logic [DATA_W-1:0] bytes [CAPACITY];

	assign accept = start && !busy_q;
	assign pos_m  = MW'(position);
	assign cnt_m  = MW'(count_q);
	assign tgt    = position - POS_W'(1);
	assign ins_ok = (count_q < CW'(CAPACITY)) && (position != '0) &&
			({1'b0, pos_m} <= ({1'b0, cnt_m} + (MW+1)'(1)));
	assign rng_ok = (position != '0) && (pos_m <= cnt_m);
	assign launch = accept && ((op == OP_FIND) ||
			((op == OP_READ || op == OP_DELETE) && rng_ok));
	assign retire = qry[CAPACITY].vld;

	always_comb begin
		ctl.ins   = accept && (op == OP_INSERT) && ins_ok;
		ctl.del   = retire && del_q;
		ctl.tgt   = ctl.ins ? tgt : del_tgt_q;
		ctl.value = value;
	end

	always_comb begin
		qry[0].vld   = launch;
		qry[0].find  = (op == OP_FIND);
		qry[0].tgt   = tgt;
		qry[0].value = value;
		qry[0].hit   = 1'b0;
		qry[0].data  = '0;
		qry[0].found = '0;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;
		if (i == 0) begin : g_first
			assign left = bytes[i];
		end else begin : g_mid_l
			assign left = bytes[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = bytes[i];
		end else begin : g_mid_r
			assign right = bytes[i+1];
		end
		pbl_cell #(
			.CAPACITY(CAPACITY),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl_i(ctl),
			.left_i(left),
			.right_i(right),
			.count_i(count_q),
			.qry_i(qry[i]),
			.byte_o(bytes[i]),
			.qry_o(qry[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			del_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
				del_q  <= (op == OP_DELETE);
			end else if (accept) begin
				done_q <= 1'b1;
				if (ctl.ins) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (retire) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				if (del_q) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			del_tgt_q <= tgt;
		end
		if (accept && !launch) begin
			data_q   <= '0;
			found_q  <= '0;
			status_q <= ctl.ins ? ST_OK : ST_RANGE;
		end else if (retire) begin
			data_q   <= qry[CAPACITY].find ? '0 : qry[CAPACITY].data;
			found_q  <= (qry[CAPACITY].find && qry[CAPACITY].hit) ?
					qry[CAPACITY].found : '0;
			status_q <= (qry[CAPACITY].find && !qry[CAPACITY].hit) ?
					ST_NOT_FOUND : ST_OK;
		end
	end

	assign busy           = busy_q;
	assign done           = done_q;
	assign data           = data_q;
	assign found_position = found_q;
	assign count          = POS_W'(count_q);
	assign status         = status_q;

endmodule

// File: rtl/pbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbl_checker
// Port-level checks on the positional byte list, bound to the top level.
// ----------------------------------------------------------------------------
module pbl_checker #(
	parameter int CAPACITY = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [pbl_pkg::OP_W-1:0]     op,
	input logic [pbl_pkg::POS_W-1:0]    position,
	input logic [pbl_pkg::DATA_W-1:0]   value,
	input logic                         done,
	input logic [pbl_pkg::DATA_W-1:0]   data,
	input logic [pbl_pkg::POS_W-1:0]    found_position,
	input logic [pbl_pkg::POS_W-1:0]    count,
	input logic [pbl_pkg::STAT_W-1:0]   status
);
	import pbl_pkg::*;

	logic unused_ok;
	assign unused_ok = ^{position, value};

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	a_insert_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_INSERT) |=> (done && !busy))
		else $error("insert result not in next cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_RANGE ||
			status == ST_NOT_FOUND))
		else $error("bad status code");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (found_position == '0 && data == '0))
		else $error("failed request carries data");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((CAPACITY > 31) || (int'(count) <= CAPACITY)))
		else $error("count above capacity");

endmodule

bind positional_byte_list_core pbl_checker #(.CAPACITY(CAPACITY)) u_pbl_checker (.*);

// File: bench/positional_byte_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_byte_list_checker
// Watches the request and result channels of the positional byte list. It
// keeps its own copy of the list, works out the result of every accepted
// word, and compares each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module positional_byte_list_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [pbl_pkg::OP_W-1:0]   op,
	input  logic [pbl_pkg::POS_W-1:0]  position,
	input  logic [pbl_pkg::DATA_W-1:0] value,
	input  logic                       done,
	input  logic [pbl_pkg::DATA_W-1:0] data,
	input  logic [pbl_pkg::POS_W-1:0]  found_position,
	input  logic [pbl_pkg::POS_W-1:0]  count,
	input  logic [pbl_pkg::STAT_W-1:0] status,
	output int                         mismatches,
	output int                         pending,
	output int                         stored_count
);
	import pbl_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  found;
		logic [POS_W-1:0]  count;
		logic [STAT_W-1:0] status;
	} list_result_t;

	logic [DATA_W-1:0] shadow_list [CAPACITY];
	int                shadow_len;
	list_result_t      expected_results [$];
	list_result_t      observed;
	list_result_t      oldest;

	initial begin
		mismatches = 0;
		pending = 0;
		stored_count = 0;
		shadow_len = 0;
	end

	function automatic list_result_t apply_request(input logic [OP_W-1:0] o,
			input logic [POS_W-1:0] p, input logic [DATA_W-1:0] v);
		list_result_t res;
		int k;
		res = '0;
		case (o)
			OP_INSERT: begin
				if (shadow_len >= CAPACITY || p == 0 || p > shadow_len + 1) begin
					res.status = ST_RANGE;
				end else begin
					for (k = shadow_len; k >= p; k--)
						shadow_list[k] = shadow_list[k-1];
					shadow_list[p-1] = v;
					shadow_len++;
				end
			end
			OP_DELETE: begin
				if (p == 0 || p > shadow_len) begin
					res.status = ST_RANGE;
				end else begin
					res.data = shadow_list[p-1];
					for (k = p; k < shadow_len; k++)
						shadow_list[k-1] = shadow_list[k];
					shadow_len--;
				end
			end
			OP_READ: begin
				if (p == 0 || p > shadow_len)
					res.status = ST_RANGE;
				else
					res.data = shadow_list[p-1];
			end
			default: begin
				res.status = ST_NOT_FOUND;
				for (k = 0; k < shadow_len; k++) begin
					if (shadow_list[k] == v) begin
						res.found = POS_W'(k + 1);
						res.status = ST_OK;
						break;
					end
				end
			end
		endcase
		res.count = POS_W'(shadow_len);
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input list_result_t want,
			input list_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t %s: expected data=%02h found=%0d count=%0d status=%0d,",
				" got data=%02h found=%0d count=%0d status=%0d"},
				$time, what, want.data, want.found, want.count, want.status,
				got.data, got.found, got.count, got.status);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			shadow_len = 0;
			pending <= 0;
			stored_count <= 0;
		end else begin
			// check the strobe before queuing this edge's word
			if (done === 1'b1) begin
				observed.data = data;
				observed.found = found_position;
				observed.count = count;
				observed.status = status;
				if (expected_results.size() == 0) begin
					flag_mismatch("unexpected result", '0, observed);
				end else begin
					oldest = expected_results.pop_front();
					if (observed.data !== oldest.data || observed.found !== oldest.found ||
							observed.count !== oldest.count ||
							observed.status !== oldest.status)
						flag_mismatch("result mismatch", oldest, observed);
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_results.push_back(apply_request(op, position, value));
			pending <= expected_results.size();
			stored_count <= shadow_len;
		end
	end

endmodule

// File: bench/tb_positional_byte_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_byte_list_core
// Drives insert, delete, read and find words into the positional byte list:
// a directed opening over the edge cases, then random grow and shrink phases
// with idle gaps. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_positional_byte_list_core;
	import pbl_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int RAND_WORDS  = 1700;
	localparam int CYCLE_LIMIT = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [OP_W-1:0]   op = OP_INSERT;
	logic [POS_W-1:0]  position = '0;
	logic [DATA_W-1:0] value = '0;
	logic              busy;
	logic              done;
	logic [DATA_W-1:0] data;
	logic [POS_W-1:0]  found_position;
	logic [POS_W-1:0]  count;
	logic [STAT_W-1:0] status;
	int                mismatches;
	int                pending;
	int                stored_count;
	int                cycles = 0;

	positional_byte_list_core #(.CAPACITY(CAPACITY)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .position(position), .value(value),
		.done(done), .data(data), .found_position(found_position),
		.count(count), .status(status)
	);

	positional_byte_list_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .position(position), .value(value),
		.done(done), .data(data), .found_position(found_position),
		.count(count), .status(status),
		.mismatches(mismatches), .pending(pending), .stored_count(stored_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_positional_byte_list_core: errors");
			$finish;
		end
	end

	// hold the word until it is taken
	task automatic send_word(input logic [OP_W-1:0] o, input logic [POS_W-1:0] p,
			input logic [DATA_W-1:0] v);
		start <= 1'b1;
		op <= o;
		position <= p;
		value <= v;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic idle(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every result is back
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_word(input bit growing);
		int len;
		int r;
		logic [OP_W-1:0]   o;
		logic [POS_W-1:0]  p;
		logic [DATA_W-1:0] v;
		len = stored_count;
		r = $urandom_range(99);
		if (growing)
			o = r < 60 ? OP_INSERT : r < 70 ? OP_DELETE : r < 85 ? OP_READ : OP_FIND;
		else
			o = r < 15 ? OP_INSERT : r < 60 ? OP_DELETE : r < 80 ? OP_READ : OP_FIND;
		r = $urandom_range(99);
		if (r < 85)
			p = POS_W'($urandom_range(len + (o == OP_INSERT ? 1 : 0), 1));
		else if (r < 93)
			p = POS_W'($urandom_range(31));
		else
			p = POS_W'(len + 1 + $urandom_range(2));
		// a narrow alphabet makes duplicates and find hits common
		if ($urandom_range(1))
			v = DATA_W'($urandom_range(7));
		else
			v = DATA_W'($urandom_range(255));
		send_word(o, p, v);
	endtask

	initial begin
		int n;
		bit growing;
		bit calm;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_FIND, 5'd0, 8'h00);
		send_word(OP_READ, 5'd1, 8'h00);
		send_word(OP_DELETE, 5'd0, 8'h00);
		send_word(OP_INSERT, 5'd0, 8'h11);
		send_word(OP_INSERT, 5'd2, 8'h11);
		send_word(OP_INSERT, 5'd1, 8'hFF);
		send_word(OP_INSERT, 5'd1, 8'h00);
		send_word(OP_INSERT, 5'd3, 8'hA5);
		send_word(OP_INSERT, 5'd2, 8'h5A);
		send_word(OP_INSERT, 5'd5, 8'h5A);
		send_word(OP_FIND, 5'd0, 8'h5A);
		send_word(OP_READ, 5'd5, 8'h00);
		send_word(OP_READ, 5'd6, 8'h00);
		send_word(OP_DELETE, 5'd2, 8'h00);
		send_word(OP_DELETE, 5'd31, 8'hFF);
		for (n = 4; n < CAPACITY; n++)
			send_word(OP_INSERT, POS_W'($urandom_range(n + 1, 1)),
				DATA_W'($urandom_range(255)));
		send_word(OP_INSERT, 5'd1, 8'h33);
		send_word(OP_READ, 5'd16, 8'h00);
		send_word(OP_DELETE, 5'd16, 8'h00);
		drain();

		growing = 1'b0;
		for (n = 0; n < RAND_WORDS; n++) begin
			calm = n >= 700 && n < 1000;
			if (stored_count >= CAPACITY && $urandom_range(3) == 0)
				growing = 1'b0;
			else if (stored_count == 0)
				growing = 1'b1;
			else if ($urandom_range(99) < 2)
				growing = !growing;
			if (n == 1200)
				drain();
			else if (!calm && $urandom_range(99) < 19)
				idle($urandom_range(4, 1));
			random_word(growing);
		end
		drain();
		repeat (CAPACITY + 4) @(posedge clk);

		if (mismatches == 0)
			$display("tb_positional_byte_list_core: clean");
		else
			$display("tb_positional_byte_list_core: errors");
		$finish;
	end

endmodule
